/* sv/assert_macros.svh */
// Assertion macros used by the formatter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ITOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ITOA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/itoa_pkg.sv */
// Shared types, constants and helpers of the integer to ASCII formatter.
`default_nettype none
package itoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int HEX_DIGITS = VALUE_W / 4;
  localparam int CNT_W      = 4;
  localparam int PAD_W      = 6;
  localparam int SHIFT_W    = 6;
  localparam int CHAR_W     = 8;

  localparam logic [SHIFT_W-1:0] SHIFT_STEPS  = 6'd32;
  localparam logic [PAD_W-1:0]   MAX_HEX_BODY = 6'd62;

  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  localparam int FMT_SIGN_BIT   = 0;
  localparam int FMT_PREFIX_BIT = 1;
  localparam int FMT_ZPAD_BIT   = 2;

  localparam logic [CHAR_W-1:0] ASCII_0     = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] ASCII_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] ASCII_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] ASCII_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_UA    = 8'h41;

  typedef logic [1:0] char_sel_t;
  localparam char_sel_t SEL_SIGN  = 2'd0;
  localparam char_sel_t SEL_ZERO  = 2'd1;
  localparam char_sel_t SEL_X     = 2'd2;
  localparam char_sel_t SEL_DIGIT = 2'd3;

  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      load_dec_cnt;
    logic      emit;
    char_sel_t sel;
    logic      cnt_dec;
    logic      pad_dec;
  } itoa_cmd_t;

  typedef struct packed {
    logic shift_done;
    logic slot_free;
    logic sign_char;
    logic pad_nz;
    logic pad_one;
    logic cnt_zero;
  } itoa_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? ASCII_UA : ASCII_LA;
    if (d < 4'd10) begin
      digit_char = ASCII_0 + {4'b0000, d};
    end else begin
      digit_char = base + {4'b0000, d} - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

/* sv/itoa_in_if.sv */
// Request channel carrying one number and its format settings.
`default_nettype none
interface itoa_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [31:0] value;
  logic [2:0] format_flags;
  logic       upper_case;
  logic [5:0] pad_width;

  modport source (output valid, operation, value, format_flags, upper_case, pad_width,
                  input ready);
  modport sink (input valid, operation, value, format_flags, upper_case, pad_width,
                output ready);
endinterface
`default_nettype wire

/* sv/itoa_out_if.sv */
// Result channel carrying one ASCII character and an end marker.
`default_nettype none
interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink (input valid, out_char, last, output ready);
endinterface
`default_nettype wire

/* sv/integer_to_ascii_formatter_core.sv */
// Decimal: after the load the BCD shift loop runs, then a last conversion step picks the
// top digit; the optional sign and the digits then enter the output register, one per cycle
// while the output is not stalled. Hex: the optional 0x prefix, zero padding and digits
// follow, one per cycle while not stalled; passing the padding state with no pad to emit
// gives no character. One request at a time: a new one is taken only in idle, after the last
// digit. Synchronous active-low reset clears the controller state, shift counter and output valid.
`default_nettype none
`include "assert_macros.svh"
module integer_to_ascii_formatter_core import itoa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  itoa_in_if.sink    in_if,
  itoa_out_if.source out_if
);

  itoa_cmd_t cmd;
  itoa_sts_t sts;
  logic      in_ready;

  assign in_if.ready = in_ready;

  itoa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_operation (in_if.operation),
    .in_hash      (in_if.format_flags[FMT_PREFIX_BIT]),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  itoa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_if.operation),
    .in_value        (in_if.value),
    .in_format_flags (in_if.format_flags),
    .in_upper_case   (in_if.upper_case),
    .in_pad_width    (in_if.pad_width),
    .cmd             (cmd),
    .sts             (sts),
    .out_if          (out_if)
  );

  `ITOA_ASSERT_NEXT(a_busy_after_request, clk, rst_n, in_if.valid && in_ready, !in_ready)
  `ITOA_ASSERT_IMP(a_emit_needs_slot, clk, rst_n, cmd.emit, sts.slot_free)
  `ITOA_ASSERT_IMP(a_step_before_done, clk, rst_n, cmd.conv_step, !sts.shift_done)
  `ITOA_ASSERT_IMP(a_load_only_idle, clk, rst_n, cmd.load, in_ready && !cmd.emit)

endmodule
`default_nettype wire

/* sv/itoa_dp.sv */
// Datapath: binary to BCD shifter, digit counters and the output register.
`default_nettype none
module itoa_dp import itoa_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_operation,
  input  wire logic [31:0]     in_value,
  input  wire logic [2:0]      in_format_flags,
  input  wire logic            in_upper_case,
  input  wire logic [5:0]      in_pad_width,
  input  wire itoa_cmd_t       cmd,
  output itoa_sts_t            sts,
  itoa_out_if.source           out_if
);

  logic                op_r, upper_r, neg_r, plus_r;
  logic [VALUE_W-1:0]  value_r;
  logic [BCD_W-1:0]    bcd_r;
  logic [SHIFT_W-1:0]  shift_cnt_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PAD_W-1:0]    pad_cnt_r;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r;

  logic [BCD_W-1:0]    bcd_adj;
  logic [CNT_W-1:0]    dec_top;
  logic [2:0]          hex_top;
  logic [PAD_W-1:0]    pad_lim, hex_digits;
  logic [3:0]          cur_digit;
  logic                in_neg;

  // add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                     : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    dec_top = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) dec_top = CNT_W'(i);
    end
  end

  always_comb begin
    hex_top = '0;
    for (int i = 0; i < HEX_DIGITS; i++) begin
      if (in_value[i*4 +: 4] != 4'd0) hex_top = 3'(i);
    end
  end

  assign pad_lim    = (in_pad_width > MAX_HEX_BODY) ? MAX_HEX_BODY : in_pad_width;
  assign hex_digits = {3'b000, hex_top} + 6'd1;
  assign in_neg     = (in_operation == OP_DEC) && in_value[VALUE_W-1];

  assign cur_digit = (op_r == OP_HEX) ? value_r[{cnt_r[2:0], 2'b00} +: 4]
                                      : bcd_r[{cnt_r, 2'b00} +: 4];

  always_comb begin
    case (cmd.sel)
      SEL_SIGN:  out_char_nxt = neg_r ? ASCII_MINUS : ASCII_PLUS;
      SEL_ZERO:  out_char_nxt = ASCII_0;
      SEL_X:     out_char_nxt = upper_r ? ASCII_UX : ASCII_LX;
      SEL_DIGIT: out_char_nxt = digit_char(cur_digit, upper_r && (op_r == OP_HEX));
      default:   out_char_nxt = ASCII_0;
    endcase
  end

  assign out_valid_nxt = cmd.emit || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      shift_cnt_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        shift_cnt_r <= (in_operation == OP_DEC) ? SHIFT_STEPS : '0;
      end else if (cmd.conv_step) begin
        shift_cnt_r <= shift_cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      upper_r <= in_upper_case;
      neg_r   <= in_neg;
      plus_r  <= in_format_flags[FMT_SIGN_BIT];
      value_r <= in_neg ? (32'd0 - in_value) : in_value;
      bcd_r   <= '0;
      cnt_r   <= {1'b0, hex_top};
      if ((in_operation == OP_HEX) && in_format_flags[FMT_ZPAD_BIT] && (pad_lim > hex_digits)) begin
        pad_cnt_r <= pad_lim - hex_digits;
      end else begin
        pad_cnt_r <= '0;
      end
    end else begin
      if (cmd.conv_step) begin
        bcd_r   <= {bcd_adj[BCD_W-2:0], value_r[VALUE_W-1]};
        value_r <= {value_r[VALUE_W-2:0], 1'b0};
      end
      if (cmd.load_dec_cnt) begin
        cnt_r <= dec_top;
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - 4'd1;
      end
      if (cmd.pad_dec) pad_cnt_r <= pad_cnt_r - 6'd1;
    end
    if (cmd.emit) begin
      out_char_r <= out_char_nxt;
      out_last_r <= (cmd.sel == SEL_DIGIT) && (cnt_r == '0);
    end
  end

  assign sts.shift_done = (shift_cnt_r == '0);
  assign sts.slot_free  = !out_valid_r || out_if.ready;
  assign sts.sign_char  = neg_r || plus_r;
  assign sts.pad_nz     = (pad_cnt_r != '0);
  assign sts.pad_one    = (pad_cnt_r == 6'd1);
  assign sts.cnt_zero   = (cnt_r == '0);

  assign out_if.valid    = out_valid_r;
  assign out_if.out_char = out_char_r;
  assign out_if.last     = out_last_r;

endmodule
`default_nettype wire

/* sv/itoa_ctrl.sv */
// Controller: sequences conversion, sign, prefix, padding and digit output.
`default_nettype none
module itoa_ctrl import itoa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_operation,
  input  wire logic      in_hash,
  output logic           in_ready,
  input  wire itoa_sts_t sts,
  output itoa_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_PFX0 = 3'd3;
  localparam logic [2:0] S_PFXX = 3'd4;
  localparam logic [2:0] S_PAD  = 3'd5;
  localparam logic [2:0] S_DIG  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_DIGIT;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_operation == OP_DEC) begin
            state_nxt = S_CONV;
          end else begin
            state_nxt = in_hash ? S_PFX0 : S_PAD;
          end
        end
      end
      S_CONV: begin
        if (sts.shift_done) begin
          cmd.load_dec_cnt = 1'b1;
          state_nxt = sts.sign_char ? S_SIGN : S_DIG;
        end else begin
          cmd.conv_step = 1'b1;
        end
      end
      S_SIGN: begin
        cmd.sel = SEL_SIGN;
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_DIG;
        end
      end
      S_PFX0: begin
        cmd.sel = SEL_ZERO;
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_PFXX;
        end
      end
      S_PFXX: begin
        cmd.sel = SEL_X;
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        cmd.sel = SEL_ZERO;
        if (!sts.pad_nz) begin
          state_nxt = S_DIG;
        end else if (sts.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.pad_dec = 1'b1;
          if (sts.pad_one) state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        cmd.sel = SEL_DIGIT;
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.cnt_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.cnt_dec = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire
